### rtl/rrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the rotator relay positioner: field widths,
// register map, phase codes and the item passed from front end to back end.
// ----------------------------------------------------------------------------
package rrp_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int ADC_W    = 10;
    localparam int ANGLE_W  = 9;
    localparam int TGT_W    = 10;
    localparam int IVL_W    = 16;
    localparam int POS_W    = 20;
    localparam int PHASE_W  = 4;
    localparam int ECNT_W   = 16;

    // Scaling datapath: signed ADC difference and product magnitude
    localparam int DIFF_W     = ADC_W + 1;
    localparam int PROD_W     = DIFF_W + ANGLE_W + 1;
    localparam int PROD_MAG_W = 19;
    localparam int CMP_W      = POS_W + 2;

    // Stream payload widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_ADC    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ADC    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_READ_IVL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ON     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE     = 3'd6;

    // Register reset values
    localparam logic [ADC_W-1:0]   RST_MIN_ADC    = 10'd0;
    localparam logic [ADC_W-1:0]   RST_MAX_ADC    = 10'd1023;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 9'd450;
    localparam logic [ANGLE_W-1:0] RST_HYSTERESIS = 9'd2;
    localparam logic [IVL_W-1:0]   RST_READ_IVL   = 16'd100;
    localparam logic [TIME_W-1:0]  RST_MAX_ON     = 32'd60000;
    localparam logic [TIME_W-1:0]  RST_SETTLE     = 32'd1000;

    // Sequencer phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START_RIGHT = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RIGHT       = 4'd2;
    localparam logic [PHASE_W-1:0] PH_START_LEFT  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEFT        = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STOP        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SETTLE      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_EMERGENCY   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_HALTED      = 4'd8;

    localparam logic [ECNT_W-1:0] ECNT_MAX = '1;

    // Queue between front end and back end
    localparam int QUEUE_DEPTH = 2;

    // One poll after classification: time, scaled product as sign and
    // magnitude, and the target angle
    typedef struct packed {
        logic [TIME_W-1:0]     now_ms;
        logic                  prod_neg;
        logic [PROD_MAG_W-1:0] prod_mag;
        logic [TGT_W-1:0]      target_angle;
    } rrp_item_t;

endpackage

### rtl/rrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_front
// Front end: accepts polls, forms the offset ADC difference and the scaled
// product, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module rrp_front
    import rrp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [ADC_W-1:0]    min_adc,
    input  logic [ANGLE_W-1:0]  max_angle,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // now_ms, adc_sample, target_angle
    output logic                push,
    output rrp_item_t           push_item,
    input  logic                queue_ready
);

    logic                     hold_valid_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [TGT_W-1:0]         tgt_reg;

    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_abs;
    logic                     accept;

    assign s_tready = !hold_valid_reg || queue_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = hold_valid_reg && queue_ready;

    // Capture the poll and subtract the zero offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (push) begin
            hold_valid_reg <= 1'b0;
        end
        if (accept) begin
            now_reg  <= s_tdata[TIME_W-1:0];
            diff_reg <= $signed({1'b0, s_tdata[TIME_W +: ADC_W]})
                        - $signed({1'b0, min_adc});
            tgt_reg  <= s_tdata[TIME_W+ADC_W +: TGT_W];
        end
    end

    // Scale by the full-span angle, split into sign and magnitude
    always_comb begin
        prod     = PROD_W'(diff_reg) * $signed({{(PROD_W-ANGLE_W){1'b0}}, max_angle});
        prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        push_item.now_ms       = now_reg;
        push_item.prod_neg     = prod[PROD_W-1];
        push_item.prod_mag     = prod_abs[PROD_MAG_W-1:0];
        push_item.target_angle = tgt_reg;
    end

endmodule

### rtl/rrp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_queue
// Short register queue between front end and back end.
// ----------------------------------------------------------------------------
module rrp_queue
    import rrp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  rrp_item_t push_item,
    output logic      queue_ready,
    input  logic      pop,
    output logic      pop_valid,
    output rrp_item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    rrp_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign queue_ready = (count_reg != FULL_CNT);
    assign pop_valid   = (count_reg != '0);
    assign pop_item    = slot_reg[rd_ptr_reg];
    assign do_pop      = pop && pop_valid;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && count_reg == FULL_CNT))
        else $error("queue written while full");

endmodule

### rtl/rrp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrp_divider
    import rrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [PROD_MAG_W-1:0] dividend,
    input  logic [ADC_W-1:0]      divisor,
    output logic                  busy,
    output logic                  done,
    output logic [PROD_MAG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_MAG_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(PROD_MAG_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ADC_W-1:0]      rem_reg;
    logic [PROD_MAG_W-1:0] quo_reg;
    logic [ADC_W-1:0]      dvs_reg;

    logic [ADC_W:0]        trial;
    logic [ADC_W:0]        trial_sub;
    logic                  fits;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial     = {rem_reg, quo_reg[PROD_MAG_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
    end

    // Iterate over the quotient bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEPS;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[PROD_MAG_W-2:0], fits};
            rem_reg <= fits ? trial_sub[ADC_W-1:0] : trial[ADC_W-1:0];
        end
    end

endmodule

### rtl/rrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_back
// Back end: resamples the position through the divider when the read
// interval has run out, steps the phase sequencer and registers the result.
// ----------------------------------------------------------------------------
module rrp_back
    import rrp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [ADC_W-1:0]    max_adc,
    input  logic [ANGLE_W-1:0]  hysteresis,
    input  logic [IVL_W-1:0]    read_interval_ms,
    input  logic [TIME_W-1:0]   max_on_ms,
    input  logic [TIME_W-1:0]   settle_ms,
    input  logic                pop_valid,
    input  rrp_item_t           pop_item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;

    logic [1:0]              st_reg;
    rrp_item_t               item_reg;
    logic [PHASE_W-1:0]      phase_reg;
    logic signed [POS_W-1:0] position_reg;
    logic [TIME_W-1:0]       last_read_reg;
    logic [TIME_W-1:0]       mark_reg;
    logic [ECNT_W-1:0]       ecnt_reg;
    logic                    left_reg;
    logic                    right_reg;
    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg;

    logic [PHASE_W-1:0]      phase_next;
    logic [TIME_W-1:0]       mark_next;
    logic [ECNT_W-1:0]       ecnt_next;
    logic                    left_next;
    logic                    right_next;

    logic                    resample;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [PROD_MAG_W-1:0]   div_quo;
    logic [ADC_W-1:0]        div_dvs;
    logic [POS_W-1:0]        quo_ext;
    logic                    step_fire;

    logic signed [CMP_W-1:0] pos_ext;
    logic signed [CMP_W-1:0] hyst_ext;
    logic signed [CMP_W-1:0] tgt_ext;
    logic signed [CMP_W-1:0] pos_plus;
    logic signed [CMP_W-1:0] pos_minus;
    logic [TIME_W-1:0]       run_time;

    assign resample  = (pop_item.now_ms - last_read_reg) > {16'd0, read_interval_ms};
    assign pop       = (st_reg == ST_IDLE) && pop_valid;
    assign div_start = pop && resample;
    assign div_dvs   = (max_adc == '0) ? ADC_W'(1) : max_adc;
    assign quo_ext   = {1'b0, div_quo};
    assign step_fire = (st_reg == ST_STEP) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    rrp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (pop_item.prod_mag),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Phase sequencer step
    always_comb begin
        pos_ext    = CMP_W'(position_reg);
        hyst_ext   = $signed({{(CMP_W-ANGLE_W){1'b0}}, hysteresis});
        tgt_ext    = CMP_W'($signed(item_reg.target_angle));
        pos_plus   = pos_ext + hyst_ext;
        pos_minus  = pos_ext - hyst_ext;
        run_time   = item_reg.now_ms - mark_reg;
        phase_next = phase_reg;
        mark_next  = mark_reg;
        ecnt_next  = ecnt_reg;
        left_next  = left_reg;
        right_next = right_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (pos_plus < tgt_ext) begin
                    phase_next = PH_START_RIGHT;
                end else if (pos_minus > tgt_ext) begin
                    phase_next = PH_START_LEFT;
                end
            end
            PH_START_RIGHT: begin
                left_next  = 1'b0;
                right_next = 1'b1;
                mark_next  = item_reg.now_ms;
                phase_next = PH_RIGHT;
            end
            PH_RIGHT: begin
                if (pos_plus >= tgt_ext) begin
                    phase_next = PH_STOP;
                end else if (run_time >= max_on_ms) begin
                    phase_next = PH_EMERGENCY;
                end
            end
            PH_START_LEFT: begin
                left_next  = 1'b1;
                right_next = 1'b0;
                mark_next  = item_reg.now_ms;
                phase_next = PH_LEFT;
            end
            PH_LEFT: begin
                if (pos_minus <= tgt_ext) begin
                    phase_next = PH_STOP;
                end else if (run_time >= max_on_ms) begin
                    phase_next = PH_EMERGENCY;
                end
            end
            PH_STOP: begin
                left_next  = 1'b0;
                right_next = 1'b0;
                mark_next  = item_reg.now_ms;
                phase_next = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (run_time >= settle_ms) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_EMERGENCY: begin
                left_next  = 1'b0;
                right_next = 1'b0;
                if (ecnt_reg != ECNT_MAX) begin
                    ecnt_next = ecnt_reg + 1'b1;
                end
                phase_next = PH_HALTED;
            end
            PH_HALTED: begin
                phase_next = PH_HALTED;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Control flow: pop, divide, step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            position_reg  <= '0;
            last_read_reg <= '0;
            mark_reg      <= '0;
            ecnt_reg      <= '0;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        st_reg <= resample ? ST_DIV : ST_STEP;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        position_reg  <= item_reg.prod_neg ? -$signed(quo_ext)
                                                           : $signed(quo_ext);
                        last_read_reg <= item_reg.now_ms;
                        st_reg        <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (step_fire) begin
                        phase_reg <= phase_next;
                        mark_reg  <= mark_next;
                        ecnt_reg  <= ecnt_next;
                        left_reg  <= left_next;
                        right_reg <= right_next;
                        st_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
            if (step_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the popped item and the result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= pop_item;
        end
        if (step_fire) begin
            out_data_reg <= {6'd0, ecnt_next, phase_next, position_reg,
                             right_next, left_next};
        end
    end

    a_relays_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(left_reg && right_reg))
        else $error("both relays driven");

    a_halted_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALTED |=> phase_reg == PH_HALTED)
        else $error("left halted phase without reset");

    a_ecnt_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ecnt_reg >= $past(ecnt_reg))
        else $error("emergency count decreased");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> st_reg == ST_DIV)
        else $error("divider running outside divide state");

endmodule

### rtl/rotator_relay_positioner_core.sv
`timescale 1ns / 1ps
// Path: a poll is held in the front end, written to the queue, popped by
//   the back end, divided when resampled, and stepped into the result register.
// Throughput: the back end pops the next poll only once the current one has
//   stepped; stepping waits while the result register is still held.
// Reset: aresetn low, sampled on aclk, restores registers and clears state.
// ----------------------------------------------------------------------------
// rotator_relay_positioner_core
// Rotator relay positioner: scales the position ADC reading to degrees and
// drives left and right relays toward the target angle, with timeouts.
// ----------------------------------------------------------------------------
module rotator_relay_positioner_core
    import rrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // now_ms, adc_sample, target_angle
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata   // relay_left, relay_right,
                                            // position_deg, phase,
                                            // emergency_count
);

    logic [ADC_W-1:0]     min_adc_reg;
    logic [ADC_W-1:0]     max_adc_reg;
    logic [ANGLE_W-1:0]   max_angle_reg;
    logic [ANGLE_W-1:0]   hyst_reg;
    logic [IVL_W-1:0]     ivl_reg;
    logic [TIME_W-1:0]    max_on_reg;
    logic [TIME_W-1:0]    settle_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    logic                 push;
    rrp_item_t            push_item;
    logic                 queue_ready;
    logic                 pop;
    logic                 pop_valid;
    rrp_item_t            pop_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_adc_reg   <= RST_MIN_ADC;
            max_adc_reg   <= RST_MAX_ADC;
            max_angle_reg <= RST_MAX_ANGLE;
            hyst_reg      <= RST_HYSTERESIS;
            ivl_reg       <= RST_READ_IVL;
            max_on_reg    <= RST_MAX_ON;
            settle_reg    <= RST_SETTLE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_ADC:    min_adc_reg   <= pwdata[ADC_W-1:0];
                REG_MAX_ADC:    max_adc_reg   <= pwdata[ADC_W-1:0];
                REG_MAX_ANGLE:  max_angle_reg <= pwdata[ANGLE_W-1:0];
                REG_HYSTERESIS: hyst_reg      <= pwdata[ANGLE_W-1:0];
                REG_READ_IVL:   ivl_reg       <= pwdata[IVL_W-1:0];
                REG_MAX_ON:     max_on_reg    <= pwdata[TIME_W-1:0];
                REG_SETTLE:     settle_reg    <= pwdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            REG_MIN_ADC:    prdata = APB_DATA_W'(min_adc_reg);
            REG_MAX_ADC:    prdata = APB_DATA_W'(max_adc_reg);
            REG_MAX_ANGLE:  prdata = APB_DATA_W'(max_angle_reg);
            REG_HYSTERESIS: prdata = APB_DATA_W'(hyst_reg);
            REG_READ_IVL:   prdata = APB_DATA_W'(ivl_reg);
            REG_MAX_ON:     prdata = max_on_reg;
            REG_SETTLE:     prdata = settle_reg;
            default:        prdata = '0;
        endcase
    end

    rrp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .min_adc     (min_adc_reg),
        .max_angle   (max_angle_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready)
    );

    rrp_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready),
        .pop         (pop),
        .pop_valid   (pop_valid),
        .pop_item    (pop_item)
    );

    rrp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .max_adc          (max_adc_reg),
        .hysteresis       (hyst_reg),
        .read_interval_ms (ivl_reg),
        .max_on_ms        (max_on_reg),
        .settle_ms        (settle_reg),
        .pop_valid        (pop_valid),
        .pop_item         (pop_item),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

### sim/rotator_relay_positioner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotator_relay_positioner_core_tb
// Self-checking bench for the rotator relay positioner. Polls go in on the
// input stream, relay and position reports come back on the result stream.
// A poll-level model of the scaling and the phase sequencer predicts every
// report, and the reports are compared field by field in order. Directed
// polls walk through a full right turn, a left turn, settle and time wrap.
// Random phases then run under several register settings, including the
// zero divisor and an emergency stop at the end.
// ----------------------------------------------------------------------------
module rotator_relay_positioner_core_tb;
    import rrp_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_LEN   = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 30;

    // Unused register slot; a write there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Input and report field positions
    localparam int ADC_LSB   = TIME_W;
    localparam int TGT_LSB   = TIME_W + ADC_W;
    localparam int POS_LSB   = 2;
    localparam int PHASE_LSB = POS_LSB + POS_W;
    localparam int ECNT_LSB  = PHASE_LSB + PHASE_W;

    // ------------------------------------------------------------------------
    // Poll-level model of the positioner and store of pending reports
    // ------------------------------------------------------------------------
    class relay_predictor;
        bit [ADC_W-1:0]   min_adc;
        bit [ADC_W-1:0]   max_adc;
        bit [ANGLE_W-1:0] max_angle;
        bit [ANGLE_W-1:0] hysteresis;
        bit [IVL_W-1:0]   read_ivl;
        bit [TIME_W-1:0]  max_on;
        bit [TIME_W-1:0]  settle;

        logic [PHASE_W-1:0] phase;
        int                 position;
        bit [TIME_W-1:0]    last_read;
        bit [TIME_W-1:0]    mark;
        bit [ECNT_W-1:0]    stops;
        bit                 left_on;
        bit                 right_on;

        bit [M_DATA_W-1:0] pending_reports[$];
        int                errors;

        function new();
            min_adc    = RST_MIN_ADC;
            max_adc    = RST_MAX_ADC;
            max_angle  = RST_MAX_ANGLE;
            hysteresis = RST_HYSTERESIS;
            read_ivl   = RST_READ_IVL;
            max_on     = RST_MAX_ON;
            settle     = RST_SETTLE;
            phase      = PH_IDLE;
            position   = 0;
            last_read  = '0;
            mark       = '0;
            stops      = '0;
            left_on    = 1'b0;
            right_on   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(bit [REG_IDX_W-1:0] idx, bit [APB_DATA_W-1:0] value);
            case (idx)
                REG_MIN_ADC:    min_adc    = value[ADC_W-1:0];
                REG_MAX_ADC:    max_adc    = value[ADC_W-1:0];
                REG_MAX_ANGLE:  max_angle  = value[ANGLE_W-1:0];
                REG_HYSTERESIS: hysteresis = value[ANGLE_W-1:0];
                REG_READ_IVL:   read_ivl   = value[IVL_W-1:0];
                REG_MAX_ON:     max_on     = value[TIME_W-1:0];
                REG_SETTLE:     settle     = value[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted poll and queue its report
        function void note_poll(bit [TIME_W-1:0] now, bit [ADC_W-1:0] adc,
                                bit [TGT_W-1:0] tgt_raw);
            int     target;
            int     hyst;
            longint prod;
            longint divisor;
            target = int'($signed(tgt_raw));
            hyst   = int'(hysteresis);

            // Resample the position once the read interval has passed
            if ((now - last_read) > read_ivl) begin
                prod     = (longint'(adc) - longint'(min_adc)) * longint'(max_angle);
                divisor  = (max_adc == 0) ? 1 : longint'(max_adc);
                position = int'(prod / divisor);
                last_read = now;
            end

            case (phase)
                PH_IDLE: begin
                    if (position + hyst < target)
                        phase = PH_START_RIGHT;
                    else if (position - hyst > target)
                        phase = PH_START_LEFT;
                end
                PH_START_RIGHT: begin
                    left_on  = 1'b0;
                    right_on = 1'b1;
                    mark     = now;
                    phase    = PH_RIGHT;
                end
                PH_RIGHT: begin
                    if (position + hyst >= target)
                        phase = PH_STOP;
                    else if ((now - mark) >= max_on)
                        phase = PH_EMERGENCY;
                end
                PH_START_LEFT: begin
                    left_on  = 1'b1;
                    right_on = 1'b0;
                    mark     = now;
                    phase    = PH_LEFT;
                end
                PH_LEFT: begin
                    if (position - hyst <= target)
                        phase = PH_STOP;
                    else if ((now - mark) >= max_on)
                        phase = PH_EMERGENCY;
                end
                PH_STOP: begin
                    left_on  = 1'b0;
                    right_on = 1'b0;
                    mark     = now;
                    phase    = PH_SETTLE;
                end
                PH_SETTLE: begin
                    if ((now - mark) >= settle)
                        phase = PH_IDLE;
                end
                PH_EMERGENCY: begin
                    left_on  = 1'b0;
                    right_on = 1'b0;
                    if (stops != ECNT_MAX)
                        stops++;
                    phase = PH_HALTED;
                end
                PH_HALTED: ;
                default: phase = PH_IDLE;
            endcase

            pending_reports.push_back({6'b0, stops, phase, position[POS_W-1:0],
                                       right_on, left_on});
        endfunction

        function void compare_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted report with the oldest pending one
        function void check_report(bit [M_DATA_W-1:0] got);
            bit [M_DATA_W-1:0] want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual 0x%0h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("relay_left", 32'(want[0]), 32'(got[0]));
            compare_field("relay_right", 32'(want[1]), 32'(got[1]));
            compare_field("position_deg", 32'(want[POS_LSB +: POS_W]),
                          32'(got[POS_LSB +: POS_W]));
            compare_field("phase", 32'(want[PHASE_LSB +: PHASE_W]),
                          32'(got[PHASE_LSB +: PHASE_W]));
            compare_field("emergency_count", 32'(want[ECNT_LSB +: ECNT_W]),
                          32'(got[ECNT_LSB +: ECNT_W]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // now_ms, adc_sample, target_angle
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // relay_left, relay_right, position_deg,
                                      // phase, emergency_count

    relay_predictor poll_model = new();

    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_req      = 1'b0;
    int stall_count   = 0;

    rotator_relay_positioner_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Monitor: note accepted polls, check accepted reports
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                poll_model.note_poll(s_tdata[TIME_W-1:0], s_tdata[ADC_LSB +: ADC_W],
                                     s_tdata[TGT_LSB +: TGT_W]);
            if (m_tvalid && m_tready)
                poll_model.check_report(m_tdata);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("rotator_relay_positioner_core_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report receiver: random stalls and one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (receiver_gaps && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic apb_write(input bit [REG_IDX_W-1:0] idx, input bit [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        poll_model.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one poll, with an optional idle burst ahead of it
    task automatic send_poll(input bit [TIME_W-1:0] now, input bit [ADC_W-1:0] adc,
                             input int target);
        int gap;
        @(negedge aclk);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = '0;
        s_tdata[TIME_W-1:0]        = now;
        s_tdata[ADC_LSB +: ADC_W]  = adc;
        s_tdata[TGT_LSB +: TGT_W]  = target[TGT_W-1:0];
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until every report is back, then let the back end go quiet
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (poll_model.pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic configure(input bit [ADC_W-1:0] min_adc, input bit [ADC_W-1:0] max_adc,
                             input bit [ANGLE_W-1:0] max_angle,
                             input bit [ANGLE_W-1:0] hyst, input bit [IVL_W-1:0] ivl,
                             input bit [TIME_W-1:0] max_on, input bit [TIME_W-1:0] settle);
        drain();
        apb_write(REG_MIN_ADC, APB_DATA_W'(min_adc));
        apb_write(REG_MAX_ADC, APB_DATA_W'(max_adc));
        apb_write(REG_MAX_ANGLE, APB_DATA_W'(max_angle));
        apb_write(REG_HYSTERESIS, APB_DATA_W'(hyst));
        apb_write(REG_READ_IVL, APB_DATA_W'(ivl));
        apb_write(REG_MAX_ON, max_on);
        apb_write(REG_SETTLE, settle);
    endtask

    // Mostly advancing time with held targets, with some jumps and noise
    task automatic run_polls(input int count, input int hold_at);
        bit [TIME_W-1:0] clock_ms;
        int              target;
        int              step_max;
        clock_ms = $urandom;
        target   = $urandom_range(0, 1023) - 512;
        step_max = 2 * int'(poll_model.read_ivl) + 2;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
                send_poll($urandom, ADC_W'($urandom_range(0, 1023)),
                          $urandom_range(0, 1023) - 512);
            end else begin
                if ($urandom_range(0, 7) == 0)
                    target = $urandom_range(0, 1023) - 512;
                clock_ms += $urandom_range(0, step_max);
                send_poll(clock_ms, ADC_W'($urandom_range(0, 1023)), target);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Right turn to target, stop, settle, left turn, time wrap
        send_poll(32'd0, 10'd0, 0);
        send_poll(32'd200, 10'd1023, 511);
        send_poll(32'd300, 10'd1023, 511);
        send_poll(32'd500, 10'd1023, 460);
        send_poll(32'd700, 10'd1023, 452);
        send_poll(32'd800, 10'd1023, 452);
        send_poll(32'd900, 10'd1023, 452);
        send_poll(32'd1900, 10'd0, -512);
        send_poll(32'd2000, 10'd0, -512);
        send_poll(32'd2101, 10'd1023, -512);
        send_poll(32'd2300, 10'd1023, -512);
        send_poll(32'd2400, 10'd0, 0);
        send_poll(32'd2500, 10'd0, 0);
        send_poll(32'hFFFF_FFF0, 10'd512, 0);
        send_poll(32'h0000_0100, 10'd512, 0);

        // Zero divisor, no dead band, resample whenever time advances, no settle wait
        configure(10'd0, 10'd0, 9'd1, 9'd0, 16'd0, 32'hFFFF_FFFF, 32'd0);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        run_polls(120, -1);

        // Top offset, widest band, slowest resample, endless settle
        configure(10'd1023, 10'd1, 9'd511, 9'd511, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_polls(60, -1);

        // Random settings; one phase holds the report side off for a while
        for (int p = 0; p < 4; p++) begin
            configure(ADC_W'($urandom_range(0, 400)), ADC_W'($urandom_range(1, 1023)),
                      ANGLE_W'($urandom_range(0, 511)), ANGLE_W'($urandom_range(0, 40)),
                      IVL_W'($urandom_range(0, 300)), 32'hFFFF_FFFF,
                      TIME_W'($urandom_range(0, 800)));
            run_polls(150, (p == 1) ? 70 : -1);
        end

        // No run time allowed: first turn ends in an emergency halt
        configure(ADC_W'($urandom_range(0, 200)), ADC_W'($urandom_range(1, 1023)),
                  ANGLE_W'($urandom_range(0, 511)), 9'd0, IVL_W'($urandom_range(0, 200)),
                  32'd0, TIME_W'($urandom_range(0, 300)));
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        run_polls(150, -1);

        drain();
        if (poll_model.errors == 0)
            $display("rotator_relay_positioner_core_tb OK");
        else
            $display("rotator_relay_positioner_core_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/rrp_pkg.sv
rtl/rrp_front.sv
rtl/rrp_queue.sv
rtl/rrp_divider.sv
rtl/rrp_back.sv
rtl/rotator_relay_positioner_core.sv
sim/rotator_relay_positioner_core_tb.sv
